// ===== hdl/vtpp_pkg.sv =====
`default_nettype none
package vtpp_pkg;

    // Default widths and screen geometry.
    localparam int COORD_WIDTH_DEF = 24;
    localparam int SCREEN_W_DEF    = 240;
    localparam int SCREEN_H_DEF    = 320;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Register map of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAMERA_X     = 3'd0,
        REG_CAMERA_Y     = 3'd1,
        REG_CAMERA_Z     = 3'd2,
        REG_YAW_COSINE   = 3'd3,
        REG_YAW_SINE     = 3'd4,
        REG_PITCH_COSINE = 3'd5,
        REG_PITCH_SINE   = 3'd6,
        REG_FOCAL_LENGTH = 3'd7
    } t_cfg_reg;

    // Register values after reset.
    localparam int CAMERA_X_RST = 1024;
    localparam int CAMERA_Y_RST = 1280;
    localparam int CAMERA_Z_RST = 1024;
    localparam int COSINE_RST   = 16384;
    localparam int SINE_RST     = 0;
    localparam int FOCAL_RST    = 200;

    // Screen word field widths.
    localparam int SCREEN_FIELD_W = 16;
    localparam int TRIG_W         = 16;
    localparam int FOCAL_W        = 10;

endpackage
`default_nettype wire

// ===== hdl/vtpp_point_if.sv =====
`default_nettype none
interface vtpp_point_if import vtpp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/vtpp_screen_if.sv =====
`default_nettype none
interface vtpp_screen_if import vtpp_pkg::*;;
    logic                             valid;
    logic                             ready;
    logic signed [SCREEN_FIELD_W-1:0] screen_x;
    logic signed [SCREEN_FIELD_W-1:0] screen_y;
    logic signed [SCREEN_FIELD_W-1:0] view_depth;
    logic                             visible;

    modport source (output valid, output screen_x, output screen_y, output view_depth,
                    output visible, input ready);
    modport sink (input valid, input screen_x, input screen_y, input view_depth,
                  input visible, output ready);
endinterface
`default_nettype wire

// ===== hdl/view_transform_perspective_project.sv =====
`default_nettype none
// View transform and perspective projection. Each world point word (signed, 8 fraction
// bits) is made relative to the camera, rotated about Y by the loaded yaw cosine and
// sine, then about X by the pitch cosine and sine (Q2.14), and projected onto the
// screen around its center as coord * focal / depth. One screen word leaves for every
// point word. The block takes a new point every clock cycle unless the output stalls;
// its pipeline is nine arithmetic stages, a 17-stage restoring divider that retires
// one quotient bit per stage, and the output register. When the output word is not
// taken, the whole pipeline holds. Depth is always reported (truncated toward zero,
// saturated); points in front of the 0.7 near plane come out with visible low and zero
// screen coordinates. The user must write the configuration registers through the
// plain write port while the block is idle; the block itself does not enforce this.
module view_transform_perspective_project import vtpp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int SCREEN_W    = SCREEN_W_DEF,
    parameter int SCREEN_H    = SCREEN_H_DEF,
    localparam int CFG_DATA_W = (COORD_WIDTH > TRIG_W) ? COORD_WIDTH : TRIG_W
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    vtpp_point_if.sink                        i_point,
    vtpp_screen_if.source                     o_screen
);

    // Datapath widths, all following from the coordinate width.
    localparam int DW = COORD_WIDTH + 1;        // point minus camera
    localparam int PW = DW + TRIG_W;            // first rotation products
    localparam int YW = PW + 1;                 // first rotation sums
    localparam int RW = YW - 14;                // rx, rz
    localparam int VW = RW + TRIG_W + 1;        // vy, vz
    localparam int QW = VW - 14;                // yq, zq
    localparam int MW = QW + FOCAL_W + 1;       // coord times focal
    localparam int CW = QW + 14;                // zq times screen size
    localparam int NW = QW + 15;                // numerators
    localparam int EW = QW + 1;                 // denominator 2*zq
    localparam int DIV_STEPS = 17;
    localparam int AW = EW + DIV_STEPS;         // divider remainder
    localparam int PRE = 8;                     // stages ahead of the divider

    localparam logic signed [13:0] SW_C = 14'(SCREEN_W);
    localparam logic signed [13:0] SH_C = 14'(SCREEN_H);

    // Configuration registers.
    logic signed [COORD_WIDTH-1:0] r_cam_x, r_cam_y, r_cam_z;
    logic signed [TRIG_W-1:0]      r_yc, r_ys, r_pc, r_ps;
    logic [FOCAL_W-1:0]            r_focal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= COORD_WIDTH'(CAMERA_X_RST);
            r_cam_y <= COORD_WIDTH'(CAMERA_Y_RST);
            r_cam_z <= COORD_WIDTH'(CAMERA_Z_RST);
            r_yc    <= TRIG_W'(COSINE_RST);
            r_ys    <= TRIG_W'(SINE_RST);
            r_pc    <= TRIG_W'(COSINE_RST);
            r_ps    <= TRIG_W'(SINE_RST);
            r_focal <= FOCAL_W'(FOCAL_RST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_CAMERA_X:     r_cam_x <= i_cfg_data[COORD_WIDTH-1:0];
                REG_CAMERA_Y:     r_cam_y <= i_cfg_data[COORD_WIDTH-1:0];
                REG_CAMERA_Z:     r_cam_z <= i_cfg_data[COORD_WIDTH-1:0];
                REG_YAW_COSINE:   r_yc    <= i_cfg_data[TRIG_W-1:0];
                REG_YAW_SINE:     r_ys    <= i_cfg_data[TRIG_W-1:0];
                REG_PITCH_COSINE: r_pc    <= i_cfg_data[TRIG_W-1:0];
                REG_PITCH_SINE:   r_ps    <= i_cfg_data[TRIG_W-1:0];
                REG_FOCAL_LENGTH: r_focal <= i_cfg_data[FOCAL_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline advances as a whole unless the output word is stalled.
    logic r_out_v;
    logic en;
    assign en            = !r_out_v || o_screen.ready;
    assign i_point.ready = en;

    logic [PRE-1:0]    r_pv;               // valid bits of the stages before the divider
    logic [DIV_STEPS:0] r_dv;              // valid bits of the divider stages

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= '0;
            r_dv    <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_pv    <= {r_pv[PRE-2:0], i_point.valid};
            r_dv    <= {r_dv[DIV_STEPS-1:0], r_pv[PRE-1]};
            r_out_v <= r_dv[DIV_STEPS];
        end
    end

    logic signed [FOCAL_W:0] focal_s;
    assign focal_s = $signed({1'b0, r_focal});

    // Stage registers ahead of the divider.
    logic signed [DW-1:0] r_a_dx, r_a_dy, r_a_dz;
    logic signed [PW-1:0] r_b_xc, r_b_zs, r_b_zc, r_b_xs;
    logic signed [DW-1:0] r_b_dy, r_c_dy;
    logic signed [RW-1:0] r_c_rx, r_c_rz, r_d_rx, r_e_rx, r_f_rx;
    logic signed [VW-2:0] r_d_ypc, r_d_rps, r_d_yps, r_d_rpc;
    logic signed [VW-1:0] r_e_vy, r_e_vz;
    logic signed [QW-1:0] r_f_yq, r_f_zq, r_g_zq;
    logic signed [SCREEN_FIELD_W-1:0] r_f_dep, r_g_dep, r_h_dep;
    logic                 r_f_vis, r_g_vis, r_h_vis;
    logic signed [MW-1:0] r_g_mx, r_g_my;
    logic signed [CW-1:0] r_g_cx, r_g_cy;
    logic signed [NW-1:0] r_h_nx, r_h_ny;
    logic [EW-1:0]        r_h_den;

    // Divider stages; lane 0 is screen x, lane 1 is screen y.
    logic [AW-1:0]             r_drem  [DIV_STEPS+1][2];
    logic [DIV_STEPS-1:0]      r_dq    [DIV_STEPS+1][2];
    logic                      r_dneg  [DIV_STEPS+1][2];
    logic                      r_dsat  [DIV_STEPS+1][2];
    logic [EW-1:0]             r_dden  [DIV_STEPS+1];
    logic signed [SCREEN_FIELD_W-1:0] r_ddep [DIV_STEPS+1];
    logic                      r_dvis  [DIV_STEPS+1];

    // Combinational values of the stages.
    logic signed [YW-1:0] n_sx, n_sz, t_shx, t_shz;
    logic signed [VW-1:0] n_vy, n_vz;
    logic signed [VW-1:0] t_shy, t_shzq, t_dsh;
    logic signed [VW+3:0] t_vze, t_vz10;
    logic signed [SCREEN_FIELD_W-1:0] n_dep;
    logic signed [NW-1:0] n_nx, n_ny;
    logic [NW-1:0]        t_abs [2];
    logic signed [NW-1:0] t_num [2];
    logic [AW-1:0]        n_drem [DIV_STEPS+1][2];
    logic [DIV_STEPS-1:0] n_dq   [DIV_STEPS+1][2];
    logic [AW-1:0]        t_dsub [DIV_STEPS+1][2];
    logic                 n_sat0 [2];
    logic [DIV_STEPS-1:0] t_q  [2];
    logic [DIV_STEPS-1:0] t_qn [2];
    logic signed [SCREEN_FIELD_W-1:0] n_scr [2];

    always_comb begin
        // First rotation, floored to 8 fraction bits.
        n_sx  = r_b_xc + r_b_zs;
        n_sz  = r_b_zc - r_b_xs;
        t_shx = n_sx >>> 14;
        t_shz = n_sz >>> 14;

        // Second rotation stays exact with 22 fraction bits.
        n_vy = r_d_ypc - r_d_rps;
        n_vz = r_d_yps + r_d_rpc;

        // Depth, near-plane test, and the Q.8 forms of the view y and z.
        t_shy  = r_e_vy >>> 14;
        t_shzq = r_e_vz >>> 14;
        t_vze  = (VW+4)'(r_e_vz);
        t_vz10 = (t_vze <<< 3) + (t_vze <<< 1);
        t_dsh  = (r_e_vz + (r_e_vz[VW-1] ? VW'(4194303) : VW'(0))) >>> 22;
        if (t_dsh > VW'(32767)) begin
            n_dep = 16'sd32767;
        end else if (t_dsh < -VW'(32768)) begin
            n_dep = -16'sd32768;
        end else begin
            n_dep = t_dsh[SCREEN_FIELD_W-1:0];
        end

        // Numerators of the two screen divisions.
        n_nx = (NW'(r_g_mx) <<< 1) + NW'(r_g_cx);
        n_ny = (NW'(r_g_my) <<< 1) + NW'(r_g_cy);

        // Sign and magnitude ahead of the divider.
        t_num[0] = r_h_nx;
        t_num[1] = r_h_ny;
        for (int l = 0; l < 2; l++) begin
            t_abs[l] = t_num[l][NW-1] ? NW'(-t_num[l]) : NW'(t_num[l]);
        end

        // One restoring step per divider stage, most significant quotient bit first.
        for (int l = 0; l < 2; l++) begin
            n_drem[0][l] = '0;
            n_dq[0][l]   = '0;
            t_dsub[0][l] = '0;
            n_sat0[l]    = r_drem[0][l] >= (AW'(r_dden[0]) << DIV_STEPS);
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            for (int l = 0; l < 2; l++) begin
                t_dsub[k+1][l] = AW'(r_dden[k]) << (DIV_STEPS - 1 - k);
                n_drem[k+1][l] = r_drem[k][l];
                n_dq[k+1][l]   = r_dq[k][l];
                if (r_drem[k][l] >= t_dsub[k+1][l]) begin
                    n_drem[k+1][l] = r_drem[k][l] - t_dsub[k+1][l];
                    n_dq[k+1][l][DIV_STEPS-1-k] = 1'b1;
                end
            end
        end

        // Sign, int16 saturation, and the blanking of points that are not visible.
        for (int l = 0; l < 2; l++) begin
            t_q[l]  = r_dq[DIV_STEPS][l];
            t_qn[l] = -t_q[l];
            if (!r_dvis[DIV_STEPS]) begin
                n_scr[l] = '0;
            end else if (!r_dneg[DIV_STEPS][l]) begin
                if (r_dsat[DIV_STEPS][l] || t_q[l] > DIV_STEPS'(32767)) begin
                    n_scr[l] = 16'sd32767;
                end else begin
                    n_scr[l] = t_q[l][SCREEN_FIELD_W-1:0];
                end
            end else begin
                if (r_dsat[DIV_STEPS][l] || t_q[l] > DIV_STEPS'(32768)) begin
                    n_scr[l] = -16'sd32768;
                end else begin
                    n_scr[l] = t_qn[l][SCREEN_FIELD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Relative to the camera.
            r_a_dx <= DW'(i_point.point_x) - DW'(r_cam_x);
            r_a_dy <= DW'(i_point.point_y) - DW'(r_cam_y);
            r_a_dz <= DW'(i_point.point_z) - DW'(r_cam_z);
            // Yaw products.
            r_b_xc <= r_a_dx * r_yc;
            r_b_zs <= r_a_dz * r_ys;
            r_b_zc <= r_a_dz * r_yc;
            r_b_xs <= r_a_dx * r_ys;
            r_b_dy <= r_a_dy;
            // Yaw sums.
            r_c_rx <= t_shx[RW-1:0];
            r_c_rz <= t_shz[RW-1:0];
            r_c_dy <= r_b_dy;
            // Pitch products.
            r_d_ypc <= r_c_dy * r_pc;
            r_d_rps <= r_c_rz * r_ps;
            r_d_yps <= r_c_dy * r_ps;
            r_d_rpc <= r_c_rz * r_pc;
            r_d_rx  <= r_c_rx;
            // Pitch sums.
            r_e_vy <= n_vy;
            r_e_vz <= n_vz;
            r_e_rx <= r_d_rx;
            // Depth and visibility.
            r_f_yq  <= t_shy[QW-1:0];
            r_f_zq  <= t_shzq[QW-1:0];
            r_f_rx  <= r_e_rx;
            r_f_dep <= n_dep;
            r_f_vis <= t_vz10 >= (VW+4)'(29360128);
            // Projection products.
            r_g_mx  <= r_f_rx * focal_s;
            r_g_my  <= r_f_yq * focal_s;
            r_g_cx  <= r_f_zq * SW_C;
            r_g_cy  <= r_f_zq * SH_C;
            r_g_zq  <= r_f_zq;
            r_g_dep <= r_f_dep;
            r_g_vis <= r_f_vis;
            // Numerators and denominator.
            r_h_nx  <= n_nx;
            r_h_ny  <= n_ny;
            r_h_den <= {r_g_zq, 1'b0};
            r_h_dep <= r_g_dep;
            r_h_vis <= r_g_vis;
            // Divider entry.
            for (int l = 0; l < 2; l++) begin
                r_drem[0][l] <= AW'(t_abs[l]);
                r_dq[0][l]   <= '0;
                r_dneg[0][l] <= t_num[l][NW-1];
                r_dsat[0][l] <= 1'b0;
            end
            r_dden[0] <= r_h_den;
            r_ddep[0] <= r_h_dep;
            r_dvis[0] <= r_h_vis;
            // Divider stages.
            for (int k = 0; k < DIV_STEPS; k++) begin
                for (int l = 0; l < 2; l++) begin
                    r_drem[k+1][l] <= n_drem[k+1][l];
                    r_dq[k+1][l]   <= n_dq[k+1][l];
                    r_dneg[k+1][l] <= r_dneg[k][l];
                    r_dsat[k+1][l] <= (k == 0) ? n_sat0[l] : r_dsat[k][l];
                end
                r_dden[k+1] <= r_dden[k];
                r_ddep[k+1] <= r_ddep[k];
                r_dvis[k+1] <= r_dvis[k];
            end
            // Output register.
            o_screen.screen_x   <= n_scr[0];
            o_screen.screen_y   <= n_scr[1];
            o_screen.view_depth <= r_ddep[DIV_STEPS];
            o_screen.visible    <= r_dvis[DIV_STEPS];
        end
    end

    assign o_screen.valid = r_out_v;

endmodule
`default_nettype wire
